>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthands for clocked concurrent assertions with an async reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);

`endif

>>> rtl/decd_pkg.sv
// ---------------------------------------------------------------------------
// decd_pkg
// Widths, codes, types and helpers shared by the distance error curve dropper.
// ---------------------------------------------------------------------------
`default_nettype none

package decd_pkg;

	// Field widths.
	localparam int unsigned DIST_W  = 24;
	localparam int unsigned RATE_W  = 16;
	localparam int unsigned QUOT_W  = RATE_W;
	localparam int unsigned PROD_W  = DIST_W + QUOT_W;
	localparam int unsigned APB_W   = 32;
	localparam int unsigned PADDR_W = 4;

	// Default number of curve points.
	localparam int unsigned TABLE_DEPTH_DEF = 16;

	// Reset value of the range register: 250 m in Q16.8.
	localparam logic [DIST_W-1:0] MAX_RANGE_RST = 24'd64000;

	// Item operations.
	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// Error modes.
	localparam logic MODE_CONST = 1'b0;
	localparam logic MODE_CURVE = 1'b1;

	// Register indexes (word address).
	localparam logic [1:0] REG_ERROR_MODE = 2'd0;
	localparam logic [1:0] REG_CONST_RATE = 2'd1;
	localparam logic [1:0] REG_MAX_RANGE  = 2'd2;

	typedef enum logic [1:0] {
		CAUSE_NONE   = 2'd0,
		CAUSE_RANGE  = 2'd1,
		CAUSE_RANDOM = 2'd2
	} cause_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// One curve point as stored in the table memory.
	typedef struct packed {
		logic [DIST_W-1:0] meters;
		logic [RATE_W-1:0] rate;
	} entry_t;

	// Request to and response from the serial divider.
	typedef struct packed {
		logic              start;
		logic [PROD_W-1:0] numer;
		logic [DIST_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_resp_t;

	// A packet drops on a random error when the draw lies below the rate.
	function automatic cause_t draw_cause(input logic [RATE_W-1:0] draw,
			input logic [RATE_W-1:0] rate);
		return (draw < rate) ? CAUSE_RANDOM : CAUSE_NONE;
	endfunction

endpackage

`default_nettype wire

>>> rtl/decd_ram.sv
// ---------------------------------------------------------------------------
// decd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module decd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/decd_div.sv
// ---------------------------------------------------------------------------
// decd_div
// Restoring divider giving one quotient bit per cycle for the interpolation.
// ---------------------------------------------------------------------------
`default_nettype none

module decd_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire decd_pkg::div_req_t   req,
	output decd_pkg::div_resp_t       resp
);

	import decd_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUOT_W + 1);
	localparam logic [CNT_W-1:0] STEPS = CNT_W'(QUOT_W);

	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] den_q;
	logic [QUOT_W-1:0] low_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIST_W:0]   trial;
	logic [DIST_W:0]   diff;
	logic              ge;

	// The numerator is known to be below denominator times 2^QUOT_W, so its
	// upper part already forms a valid partial remainder.
	assign trial = {rem_q, low_q[QUOT_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			low_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.numer[PROD_W-1:QUOT_W];
				low_q  <= req.numer[QUOT_W-1:0];
				den_q  <= req.denom;
				cnt_q  <= STEPS;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[DIST_W-1:0] : trial[DIST_W-1:0];
				low_q  <= {low_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], ge};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign resp.done = done_q;
	assign resp.quot = quot_q;

endmodule

`default_nettype wire

>>> rtl/distance_error_curve_dropper.sv
// ---------------------------------------------------------------------------
// distance_error_curve_dropper
// Packet drop decision from distance, with a stored distance/error-rate curve.
// ---------------------------------------------------------------------------
// The block takes one item at a time and returns one result beat for each.
// A check in constant mode, or one that falls beyond range, has its result
// registered on acceptance and moves through S_FINISH into the output
// register once that is free. Other items walk the curve table, which sits
// in a RAM read one entry per cycle: an insert scans for its place, shifts
// the tail of the table up by one place and stores the new point; a curve
// check scans for the bracketing points and, when it must interpolate,
// forms the product in S_MUL and then runs the serial divider in S_DIV. The
// next item is taken while a result still waits on the output. Registers
// sit at byte addresses 0, 4 and 8 of the APB port.
// ---------------------------------------------------------------------------
`default_nettype none

module distance_error_curve_dropper #(
	parameter int unsigned TABLE_DEPTH = decd_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// Item channel.
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic                           op,
	input  wire logic [decd_pkg::DIST_W-1:0]    distance,
	input  wire logic [decd_pkg::RATE_W-1:0]    point_rate,
	input  wire logic [decd_pkg::RATE_W-1:0]    random_draw,
	// Result channel.
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic                                drop,
	output logic      [1:0]                     drop_cause,
	output logic      [decd_pkg::RATE_W-1:0]    applied_rate,
	output logic      [1:0]                     insert_status,
	// Configuration port.
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [decd_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [decd_pkg::APB_W-1:0]     pwdata,
	output logic      [decd_pkg::APB_W-1:0]     prdata,
	output logic                                pready
);

	import decd_pkg::*;

	localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_SCAN   = 7'b0000010,
		S_SHIFT  = 7'b0000100,
		S_PLACE  = 7'b0001000,
		S_MUL    = 7'b0010000,
		S_DIV    = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	// Configuration registers.
	logic              mode_q;
	logic [RATE_W-1:0] crate_q;
	logic [DIST_W-1:0] mrange_q;
	logic [1:0]        wr_idx;

	// Control and table state.
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [DIST_W-1:0] largest_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic              rd_pend_q;
	logic [CNT_W-1:0]  pos_q;

	// Item being worked on.
	logic              op_q;
	logic [DIST_W-1:0] dist_q;
	logic [RATE_W-1:0] prate_q;
	logic [RATE_W-1:0] draw_q;

	// Bracketing points and interpolation.
	logic [DIST_W-1:0] lo_dist_q;
	logic [RATE_W-1:0] lo_rate_q;
	logic [DIST_W-1:0] hi_dist_q;
	logic [RATE_W-1:0] hi_rate_q;
	logic [PROD_W-1:0] prod_q;
	logic [DIST_W-1:0] span_q;
	logic              desc_q;
	logic              div_start_q;
	logic [DIST_W-1:0] dist_off;
	logic [RATE_W-1:0] rate_diff;
	logic [RATE_W-1:0] interp_rate;
	div_req_t          div_req;
	div_resp_t         div_resp;

	// Result waiting to enter the output register, and the output register.
	cause_t            res_cause_q;
	logic [RATE_W-1:0] res_rate_q;
	status_t           res_status_q;
	logic              out_valid_q;
	logic              out_drop_q;
	cause_t            out_cause_q;
	logic [RATE_W-1:0] out_rate_q;
	status_t           out_status_q;

	// Table memory ports.
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [$bits(entry_t)-1:0] rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	entry_t            wr_data;
	entry_t            rd_entry;
	logic [CNT_W-1:0]  idx_dec;
	logic [CNT_W-1:0]  rd_inc;
	logic              scan_eq;
	logic              scan_gt;
	logic              scan_end;
	logic              shift_end;

	// Configuration writes and reads.
	assign wr_idx = paddr[PADDR_W-1:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_CONST;
			crate_q  <= '0;
			mrange_q <= MAX_RANGE_RST;
		end else if (psel && penable && pwrite) begin
			case (wr_idx)
				REG_ERROR_MODE: mode_q   <= pwdata[0];
				REG_CONST_RATE: crate_q  <= pwdata[RATE_W-1:0];
				REG_MAX_RANGE:  mrange_q <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_ERROR_MODE: prdata = APB_W'(mode_q);
			REG_CONST_RATE: prdata = APB_W'(crate_q);
			REG_MAX_RANGE:  prdata = APB_W'(mrange_q);
			default:        prdata = '0;
		endcase
	end

	// Table memory: one curve point per word.
	decd_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_DEPTH)
	) u_decd_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_entry  = entry_t'(rd_data);
	assign idx_dec   = idx_q - CNT_W'(1);
	assign rd_inc    = rd_idx_q + CNT_W'(1);
	assign scan_eq   = rd_entry.meters == dist_q;
	assign scan_gt   = rd_entry.meters > dist_q;
	assign scan_end  = !rd_pend_q && (idx_q >= count_q);
	assign shift_end = !rd_pend_q && (idx_q == pos_q);

	// Memory addressing: a forward scan, a backward shift of the tail by one
	// place (read an entry, write it one higher the next cycle), and the
	// final store of the new point.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q[ADDR_W-1:0];
		wr_en   = 1'b0;
		wr_addr = pos_q[ADDR_W-1:0];
		wr_data = '{meters: dist_q, rate: prate_q};
		case (state_q)
			S_SCAN: begin
				rd_en = idx_q < count_q;
			end
			S_SHIFT: begin
				rd_en   = idx_q > pos_q;
				rd_addr = idx_dec[ADDR_W-1:0];
				wr_en   = rd_pend_q;
				wr_addr = rd_inc[ADDR_W-1:0];
				wr_data = rd_entry;
			end
			S_PLACE: begin
				wr_en = 1'b1;
			end
			default: ;
		endcase
	end

	// Interpolation datapath. Points are strictly increasing in distance, so
	// the offset stays below the span and the quotient never passes the rate
	// difference: the result stays between the two bracketing rates.
	assign dist_off  = dist_q - lo_dist_q;
	assign rate_diff = (hi_rate_q < lo_rate_q) ? (lo_rate_q - hi_rate_q)
	                                           : (hi_rate_q - lo_rate_q);
	assign interp_rate = desc_q ? (lo_rate_q - div_resp.quot)
	                            : (lo_rate_q + div_resp.quot);

	assign div_req.start = div_start_q;
	assign div_req.numer = prod_q;
	assign div_req.denom = span_q;

	decd_div u_decd_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.resp   (div_resp)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			largest_q    <= '0;
			idx_q        <= '0;
			rd_idx_q     <= '0;
			rd_pend_q    <= 1'b0;
			pos_q        <= '0;
			op_q         <= OP_CHECK;
			dist_q       <= '0;
			prate_q      <= '0;
			draw_q       <= '0;
			lo_dist_q    <= '0;
			lo_rate_q    <= '0;
			hi_dist_q    <= '0;
			hi_rate_q    <= '0;
			prod_q       <= '0;
			span_q       <= '0;
			desc_q       <= 1'b0;
			div_start_q  <= 1'b0;
			res_cause_q  <= CAUSE_NONE;
			res_rate_q   <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			out_drop_q   <= 1'b0;
			out_cause_q  <= CAUSE_NONE;
			out_rate_q   <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				// Take an item; range and constant-mode checks finish at once.
				S_IDLE: begin
					rd_pend_q <= 1'b0;
					idx_q     <= '0;
					pos_q     <= '0;
					if (item_valid) begin
						op_q         <= op;
						dist_q       <= distance;
						prate_q      <= point_rate;
						draw_q       <= random_draw;
						res_cause_q  <= CAUSE_NONE;
						res_rate_q   <= '0;
						res_status_q <= ST_OK;
						if (op == OP_INSERT) begin
							state_q <= (count_q == '0) ? S_PLACE : S_SCAN;
						end else if (mode_q == MODE_CONST) begin
							if (distance > mrange_q) begin
								res_cause_q <= CAUSE_RANGE;
							end else begin
								res_rate_q  <= crate_q;
								res_cause_q <= draw_cause(random_draw, crate_q);
							end
							state_q <= S_FINISH;
						end else if ((count_q == '0) || (distance > largest_q)) begin
							res_cause_q <= CAUSE_RANGE;
							state_q     <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end

				// Walk the table in order of distance, one entry per cycle.
				S_SCAN: begin
					rd_pend_q <= rd_en;
					rd_idx_q  <= idx_q;
					if (rd_en) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (rd_pend_q) begin
						if (op_q == OP_INSERT) begin
							if (scan_eq) begin
								res_status_q <= ST_DUP;
								state_q      <= S_FINISH;
							end else if (scan_gt) begin
								// Later entries are all larger: no duplicate.
								pos_q <= rd_idx_q;
								if (count_q == DEPTH_C) begin
									res_status_q <= ST_FULL;
									state_q      <= S_FINISH;
								end else begin
									idx_q     <= count_q;
									rd_pend_q <= 1'b0;
									state_q   <= S_SHIFT;
								end
							end else begin
								pos_q <= rd_inc;
							end
						end else begin
							if (scan_eq || (scan_gt && (rd_idx_q == '0))) begin
								// Exact match, or below the first point.
								res_rate_q  <= rd_entry.rate;
								res_cause_q <= draw_cause(draw_q, rd_entry.rate);
								state_q     <= S_FINISH;
							end else if (scan_gt) begin
								hi_dist_q <= rd_entry.meters;
								hi_rate_q <= rd_entry.rate;
								state_q   <= S_MUL;
							end else begin
								lo_dist_q <= rd_entry.meters;
								lo_rate_q <= rd_entry.rate;
							end
						end
					end else if (scan_end) begin
						// Every stored distance lies below the item's.
						if (op_q == OP_INSERT) begin
							if (count_q == DEPTH_C) begin
								res_status_q <= ST_FULL;
								state_q      <= S_FINISH;
							end else begin
								state_q <= S_PLACE;
							end
						end else begin
							res_rate_q  <= lo_rate_q;
							res_cause_q <= draw_cause(draw_q, lo_rate_q);
							state_q     <= S_FINISH;
						end
					end
				end

				// Move the entries at and above the insert place up by one.
				S_SHIFT: begin
					rd_pend_q <= rd_en;
					rd_idx_q  <= idx_dec;
					if (rd_en) begin
						idx_q <= idx_dec;
					end
					if (shift_end) begin
						state_q <= S_PLACE;
					end
				end

				// Store the new point.
				S_PLACE: begin
					count_q <= count_q + CNT_W'(1);
					if (dist_q > largest_q) begin
						largest_q <= dist_q;
					end
					state_q <= S_FINISH;
				end

				// Offset times rate difference, then start the division.
				S_MUL: begin
					prod_q      <= PROD_W'(dist_off) * PROD_W'(rate_diff);
					span_q      <= hi_dist_q - lo_dist_q;
					desc_q      <= hi_rate_q < lo_rate_q;
					div_start_q <= 1'b1;
					state_q     <= S_DIV;
				end

				S_DIV: begin
					div_start_q <= 1'b0;
					if (div_resp.done) begin
						res_rate_q  <= interp_rate;
						res_cause_q <= draw_cause(draw_q, interp_rate);
						state_q     <= S_FINISH;
					end
				end

				// Hand the result to the output register once it is free.
				S_FINISH: begin
					if (!out_valid_q || result_ready) begin
						out_valid_q  <= 1'b1;
						out_drop_q   <= res_cause_q != CAUSE_NONE;
						out_cause_q  <= res_cause_q;
						out_rate_q   <= res_rate_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_ready    = state_q == S_IDLE;
	assign result_valid  = out_valid_q;
	assign drop          = out_drop_q;
	assign drop_cause    = out_cause_q;
	assign applied_rate  = out_rate_q;
	assign insert_status = out_status_q;

endmodule

`default_nettype wire

>>> rtl/decd_checker.sv
// ---------------------------------------------------------------------------
// decd_checker
// Port-level assertions on the result channel of the dropper, bound to it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module decd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        result_valid,
	input wire logic                        result_ready,
	input wire logic                        drop,
	input wire logic [1:0]                  drop_cause,
	input wire logic [decd_pkg::RATE_W-1:0] applied_rate,
	input wire logic [1:0]                  insert_status
);

	import decd_pkg::*;

	logic              stalled;
	logic [RATE_W+4:0] beat;

	// A result beat that is offered but not taken, and its whole payload.
	assign stalled = result_valid && !result_ready;
	assign beat    = {drop, drop_cause, applied_rate, insert_status};

	// A stalled result beat keeps its payload.
	`ASSERT_ALWAYS(a_result_hold, clk, arst_n, stalled |=> result_valid && $stable(beat), "stalled beat changed")

	// The drop flag agrees with the cause.
	`ASSERT_ALWAYS(a_drop_cause, clk, arst_n, result_valid |-> (drop == (drop_cause != CAUSE_NONE)), "drop disagrees")

	// An ignored insert reports no drop and no rate.
	`ASSERT_NEVER(a_insert_clean, clk, arst_n, result_valid && (insert_status != ST_OK) && (drop || (applied_rate != '0)), "insert fields")

	// A packet beyond range is reported with a zero rate and no insert status.
	`ASSERT_ALWAYS(a_range_rate, clk, arst_n, result_valid && (drop_cause == CAUSE_RANGE) |-> (applied_rate == '0) && (insert_status == ST_OK), "range drop fields")

endmodule

bind distance_error_curve_dropper decd_checker u_decd_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// Testbench for distance_error_curve_dropper
// Drives packet checks and curve point inserts through the item channel,
// predicts every result beat from a model of the curve table kept here, and
// compares each result field. Registers are written and read back over the
// APB port while the block is idle. Random traffic runs under several
// sender and receiver idle patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import decd_pkg::*;

	localparam int unsigned DEPTH             = TABLE_DEPTH_DEF;
	localparam int unsigned QUIET_LIMIT       = 2000;
	localparam int unsigned SETTLE_CYCLES     = 64;
	localparam int unsigned ITEMS_PER_SETTING = 175;
	localparam longint      DIST_TOP          = (longint'(1) << DIST_W) - 1;
	// Word index with no register behind it.
	localparam logic [1:0]  REG_SPARE         = 2'd3;

	// One expected result beat.
	typedef struct {
		logic              drop;
		cause_t            cause;
		logic [RATE_W-1:0] rate;
		status_t           status;
	} verdict_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                item_valid   = 1'b0;
	logic                item_ready;
	logic                op           = OP_CHECK;
	logic [DIST_W-1:0]   distance     = '0;
	logic [RATE_W-1:0]   point_rate   = '0;
	logic [RATE_W-1:0]   random_draw  = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	logic                drop;
	logic [1:0]          drop_cause;
	logic [RATE_W-1:0]   applied_rate;
	logic [1:0]          insert_status;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [PADDR_W-1:0]  paddr        = '0;
	logic [APB_W-1:0]    pwdata       = '0;
	logic [APB_W-1:0]    prdata;
	logic                pready;

	// Idle percentages for the current phase.
	int unsigned gap_pct   = 0;
	int unsigned stall_pct = 0;

	// Predicted state of the block.
	entry_t            curve_tbl [DEPTH];
	int unsigned       point_total    = 0;
	logic [DIST_W-1:0] far_point      = '0;
	logic              mode_reg       = MODE_CONST;
	logic [RATE_W-1:0] const_rate_reg = '0;
	logic [DIST_W-1:0] range_reg      = MAX_RANGE_RST;

	verdict_t    pending_verdicts [$];
	int unsigned error_count  = 0;
	int unsigned quiet_cycles = 0;

	// Tallies for the closing summary.
	int unsigned check_count  = 0;
	int unsigned insert_count = 0;
	int unsigned range_drops  = 0;
	int unsigned random_drops = 0;
	int unsigned dup_inserts  = 0;
	int unsigned full_inserts = 0;
	int unsigned reg_writes   = 0;

	distance_error_curve_dropper #(
		.TABLE_DEPTH(DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.op           (op),
		.distance     (distance),
		.point_rate   (point_rate),
		.random_draw  (random_draw),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.drop         (drop),
		.drop_cause   (drop_cause),
		.applied_rate (applied_rate),
		.insert_status(insert_status),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Error rate of the curve at distance d; the table must not be empty.
	function automatic logic [RATE_W-1:0] curve_rate_at(input logic [DIST_W-1:0] d);
		int unsigned     i;
		entry_t          lo;
		entry_t          hi;
		longint unsigned offset;
		longint unsigned span;
		longint unsigned spread;
		longint unsigned quotient;
		i = 0;
		while (i < point_total && curve_tbl[i].meters <= d) begin
			if (curve_tbl[i].meters == d)
				return curve_tbl[i].rate;
			i++;
		end
		// Below the first point the first rate holds; past the last, the last.
		if (i == 0)
			return curve_tbl[0].rate;
		if (i >= point_total)
			return curve_tbl[i - 1].rate;
		lo = curve_tbl[i - 1];
		hi = curve_tbl[i];
		offset = 64'(d) - 64'(lo.meters);
		span = 64'(hi.meters) - 64'(lo.meters);
		// The quotient is truncated towards the lower point's rate.
		if (hi.rate >= lo.rate) begin
			spread = 64'(hi.rate) - 64'(lo.rate);
			quotient = offset * spread / span;
			return lo.rate + RATE_W'(quotient);
		end
		spread = 64'(lo.rate) - 64'(hi.rate);
		quotient = offset * spread / span;
		return lo.rate - RATE_W'(quotient);
	endfunction

	// Stores a point in distance order; duplicates are refused before fullness.
	function automatic status_t store_point(input logic [DIST_W-1:0] d,
			input logic [RATE_W-1:0] r);
		int unsigned i;
		int unsigned pos;
		for (i = 0; i < point_total; i++)
			if (curve_tbl[i].meters == d)
				return ST_DUP;
		if (point_total >= DEPTH)
			return ST_FULL;
		pos = 0;
		while (pos < point_total && curve_tbl[pos].meters < d)
			pos++;
		for (i = point_total; i > pos; i--)
			curve_tbl[i] = curve_tbl[i - 1];
		curve_tbl[pos] = {d, r};
		point_total++;
		if (d > far_point)
			far_point = d;
		return ST_OK;
	endfunction

	// Expected result of one accepted item; inserts update the table.
	function automatic verdict_t judge_item(input logic op_in, input logic [DIST_W-1:0] d,
			input logic [RATE_W-1:0] prate, input logic [RATE_W-1:0] draw);
		verdict_t v;
		logic     beyond;
		v = '{drop: 1'b0, cause: CAUSE_NONE, rate: '0, status: ST_OK};
		if (op_in == OP_INSERT) begin
			v.status = store_point(d, prate);
			insert_count++;
			if (v.status == ST_DUP)
				dup_inserts++;
			if (v.status == ST_FULL)
				full_inserts++;
		end else begin
			check_count++;
			if (mode_reg == MODE_CONST)
				beyond = d > range_reg;
			else
				beyond = (point_total == 0) || (d > far_point);
			if (beyond) begin
				v.drop = 1'b1;
				v.cause = CAUSE_RANGE;
				range_drops++;
			end else begin
				v.rate = (mode_reg == MODE_CONST) ? const_rate_reg : curve_rate_at(d);
				if (draw < v.rate) begin
					v.drop = 1'b1;
					v.cause = CAUSE_RANDOM;
					random_drops++;
				end
			end
		end
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus shaping
	// ------------------------------------------------------------------

	function automatic logic [DIST_W-1:0] clamp_dist(input longint v);
		if (v < 0)
			return '0;
		if (v > DIST_TOP)
			return '1;
		return DIST_W'(v);
	endfunction

	// Check distances gather around the table points and the range edges.
	function automatic logic [DIST_W-1:0] pick_check_distance();
		logic [DIST_W-1:0] d;
		entry_t            pt;
		pt = (point_total != 0) ? curve_tbl[$urandom_range(point_total - 1)] : '0;
		case ($urandom_range(9))
			0: d = '0;
			1: d = '1;
			2: d = pt.meters;
			3: d = clamp_dist(longint'(pt.meters) + longint'($urandom_range(6)) - 3);
			4: d = clamp_dist(longint'(far_point) + 1 + longint'($urandom_range(3)));
			5: d = clamp_dist(longint'(range_reg) + longint'($urandom_range(1)));
			6, 7: d = DIST_W'($urandom_range(far_point));
			default: d = DIST_W'($urandom_range(DIST_TOP));
		endcase
		return d;
	endfunction

	// Draws land on either side of the rate that applies at d.
	function automatic logic [RATE_W-1:0] pick_draw(input logic [DIST_W-1:0] d);
		logic [RATE_W-1:0] r;
		if (mode_reg == MODE_CONST)
			r = const_rate_reg;
		else
			r = (point_total != 0) ? curve_rate_at(d) : '0;
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return r;
			3: return r - 1'b1;
			default: return RATE_W'($urandom());
		endcase
	endfunction

	// Mostly fresh distances, some repeats of stored ones.
	function automatic logic [DIST_W-1:0] pick_insert_distance();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0 && point_total != 0)
			return curve_tbl[$urandom_range(point_total - 1)].meters;
		if (pick < 6)
			return DIST_W'($urandom_range(24'h00FFFF, 1));
		return DIST_W'($urandom_range(24'hEFFFFF, 1));
	endfunction

	function automatic logic [RATE_W-1:0] pick_point_rate();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			default: return RATE_W'($urandom());
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Sends one item beat after a random gap; called and returns at a rising edge.
	task automatic send_item(input logic op_in, input logic [DIST_W-1:0] d,
			input logic [RATE_W-1:0] prate, input logic [RATE_W-1:0] draw);
		int unsigned gap;
		verdict_t    expected;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < gap_pct)
			gap++;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		op          <= op_in;
		distance    <= d;
		point_rate  <= prate;
		random_draw <= draw;
		do @(posedge clk); while (!item_ready);
		expected = judge_item(op_in, d, prate, draw);
		pending_verdicts.insert(pending_verdicts.size(), expected);
	endtask

	task automatic send_check(input logic [DIST_W-1:0] d, input logic [RATE_W-1:0] draw);
		send_item(OP_CHECK, d, RATE_W'($urandom()), draw);
	endtask

	task automatic send_insert(input logic [DIST_W-1:0] d, input logic [RATE_W-1:0] r);
		send_item(OP_INSERT, d, r, RATE_W'($urandom()));
	endtask

	// Holds the sender back until every outstanding result has arrived.
	task automatic wait_for_verdicts();
		item_valid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
	endtask

	// Writes one register, then reads it back.
	task automatic write_reg(input logic [1:0] idx, input logic [APB_W-1:0] value);
		logic [APB_W-1:0] held;
		string            reg_name;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		reg_writes++;
		case (idx)
			REG_ERROR_MODE: mode_reg = value[0];
			REG_CONST_RATE: const_rate_reg = value[RATE_W-1:0];
			REG_MAX_RANGE:  range_reg = value[DIST_W-1:0];
			default: ;
		endcase
		// Read back with a fresh setup phase.
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		held = '0;
		reg_name = "";
		case (idx)
			REG_ERROR_MODE: begin
				held = APB_W'(mode_reg);
				reg_name = "error_mode";
			end
			REG_CONST_RATE: begin
				held = APB_W'(const_rate_reg);
				reg_name = "const_error_rate";
			end
			REG_MAX_RANGE: begin
				held = APB_W'(range_reg);
				reg_name = "max_range";
			end
			default: ;
		endcase
		if (idx != REG_SPARE && prdata !== held) begin
			$error("%s read back: expected 0x%0h, got 0x%0h", reg_name, held, prdata);
			error_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Writes all three registers once the block is idle; upper bits carry noise.
	task automatic apply_settings(input logic mode, input logic [RATE_W-1:0] rate,
			input logic [DIST_W-1:0] range);
		wait_for_verdicts();
		write_reg(REG_ERROR_MODE, {31'($urandom()), mode});
		write_reg(REG_CONST_RATE, {16'($urandom()), rate});
		write_reg(REG_MAX_RANGE, {8'($urandom()), range});
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------

	// Receiver stalls at random.
	always @(posedge clk)
		result_ready <= ($urandom_range(99) >= stall_pct);

	// Each result beat is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		verdict_t want;
		if (result_valid && result_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no item outstanding");
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				if (drop !== want.drop) begin
					$error("drop: expected %0d, got %0d", want.drop, drop);
					error_count++;
				end
				if (drop_cause !== want.cause) begin
					$error("drop_cause: expected %0d, got %0d", want.cause, drop_cause);
					error_count++;
				end
				if (applied_rate !== want.rate) begin
					$error("applied_rate: expected %0d, got %0d", want.rate, applied_rate);
					error_count++;
				end
				if (insert_status !== want.status) begin
					$error("insert_status: expected %0d, got %0d", want.status,
						insert_status);
					error_count++;
				end
			end
		end
	end

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Constant mode: range edges, rate extremes and an unmapped register.
	task automatic test_constant_rate();
		// Reset settings: constant mode, zero rate, 250 m range.
		send_check('0, '0);
		send_check(MAX_RANGE_RST, '1);
		send_check(MAX_RANGE_RST + 1'b1, '0);
		send_check('1, '0);
		// Full rate and zero range: the draw must lie strictly below the rate.
		apply_settings(MODE_CONST, '1, '0);
		send_check('0, 16'hFFFE);
		send_check('0, '1);
		send_check(24'd1, '0);
		apply_settings(MODE_CONST, 16'h8000, '1);
		send_check('1, 16'h7FFF);
		send_check(24'h123456, 16'h8000);
		// A write to the unmapped word must leave every setting alone.
		wait_for_verdicts();
		write_reg(REG_SPARE, '1);
		send_check(24'h000100, 16'h7FFF);
	endtask

	// Curve mode: empty table, duplicates, below the first point, exact hits,
	// rising and falling interpolation and the end of the curve.
	task automatic test_curve_table();
		apply_settings(MODE_CURVE, '0, MAX_RANGE_RST);
		send_check('0, '1);
		send_insert(24'h000400, 16'd100);
		send_insert(24'h000400, 16'd5);
		send_check(24'h000200, 16'd99);
		send_check(24'h000400, 16'd100);
		send_check(24'h000401, '0);
		send_insert(24'h001000, '1);
		send_check(24'h000800, '1);
		send_insert(24'hF00000, '0);
		send_check(24'h800000, '0);
		send_check(24'hEFFFFF, '0);
		send_check(24'hF00001, '0);
	endtask

	// Mixed random traffic under each idle pattern, two settings per pattern.
	task automatic test_random_traffic();
		int unsigned       phase;
		int unsigned       setting;
		int unsigned       n;
		logic [RATE_W-1:0] rate;
		logic [DIST_W-1:0] range;
		logic [DIST_W-1:0] d;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 78; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 78; end
				default: begin gap_pct = 23; stall_pct = 23; end
			endcase
			for (setting = 0; setting < 2; setting++) begin
				case ($urandom_range(3))
					0: rate = '0;
					1: rate = '1;
					default: rate = RATE_W'($urandom());
				endcase
				case ($urandom_range(3))
					0: range = '0;
					1: range = '1;
					2: range = far_point;
					default: range = DIST_W'($urandom());
				endcase
				apply_settings(((phase + setting) % 2 == 0) ? MODE_CURVE : MODE_CONST,
					rate, range);
				for (n = 0; n < ITEMS_PER_SETTING; n++) begin
					if ($urandom_range(249) == 0)
						wait_for_verdicts();
					if ($urandom_range(99) < 4) begin
						send_insert(pick_insert_distance(), pick_point_rate());
					end else begin
						d = pick_check_distance();
						send_check(d, pick_draw(d));
					end
				end
			end
		end
	endtask

	// Fills the table, then inserts into it when full and checks its far end.
	task automatic test_table_full();
		apply_settings(MODE_CURVE, '0, '1);
		while (point_total < DEPTH)
			send_insert(DIST_W'($urandom_range(24'hEFFFFF, 1)), pick_point_rate());
		send_insert('0, '0);
		send_insert('1, '1);
		send_insert(curve_tbl[0].meters, '0);
		send_check(far_point, RATE_W'($urandom()));
		send_check(clamp_dist(longint'(far_point) + 1), '0);
		send_check('0, RATE_W'($urandom()));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_constant_rate();
		test_curve_table();
		test_random_traffic();
		test_table_full();
		wait_for_verdicts();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d checks (%0d out of range, %0d random drops) and %0d inserts",
			check_count, range_drops, random_drops, insert_count);
		$display("(%0d duplicate, %0d into a full table), with %0d register writes.",
			dup_inserts, full_inserts, reg_writes);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
